// File: design/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg: shared types and constants for the indexed ordered list
// Operation and status codes, the sequencer state, and the control bundle
// that the top level broadcasts to the entry cells.
// ----------------------------------------------------------------------------
package iol_pkg;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 3;
    localparam int GATHER_W = 32;   // cells folded into one gather register

    typedef enum logic [MODE_W-1:0] {
        MODE_READ      = 3'd0,
        MODE_INS_FRONT = 3'd1,
        MODE_INS_BACK  = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_BACK  = 3'd4,
        MODE_CLEAR     = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

// File: design/iol_cell.sv
// ----------------------------------------------------------------------------
// iol_cell: one list entry
// Holds the word at a fixed list position. On insert, cells behind the slot
// take their front neighbor and the slot takes the new word; on delete, cells
// from the slot on take their back neighbor. Drives its word when read.
// ----------------------------------------------------------------------------
module iol_cell
    import iol_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 6
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IW-1:0]     at,
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] prev_word,
    input  logic [WORD_W-1:0] next_word,
    output logic [WORD_W-1:0] data,
    output logic [WORD_W-1:0] hit_word
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (MY_IDX > at)
            begin
                data_next = prev_word;
            end
            else if (MY_IDX == at)
            begin
                data_next = word;
            end
        end
        else if (ctrl.del_en && (MY_IDX >= at))
        begin
            data_next = next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_word = (ctrl.rd_en && (MY_IDX == at)) ? data_reg : '0;

endmodule

// File: design/iol_gather.sv
// ----------------------------------------------------------------------------
// iol_gather: read-out tree for the cell row
// ORs the cell read words in groups into registers, then ORs the group
// registers into one word. At most one cell drives a nonzero word.
// ----------------------------------------------------------------------------
module iol_gather
    import iol_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              load,
    input  logic [WORD_W-1:0] hit_words [CAPACITY],
    output logic [WORD_W-1:0] word
);

    localparam int NGRP = (CAPACITY + GATHER_W - 1) / GATHER_W;

    logic [WORD_W-1:0] grp_reg  [NGRP];
    logic [WORD_W-1:0] grp_next [NGRP];

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        always_comb
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GATHER_W; k++)
            begin
                if (g * GATHER_W + k < CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | hit_words[g * GATHER_W + k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb
    begin
        word = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            word = word | grp_reg[g];
        end
    end

endmodule

// File: design/indexed_ordered_list_top.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_top: bounded ordered list of signed 32-bit words
// Row of entry cells with insert/delete at a front or back index, read at a front index, and clear.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, front entry in cell 0. An insert
// or delete shifts every cell behind the slot by one place in the same clock
// edge that takes the item. A read goes through a registered OR tree over the
// cells, so each item is accepted, then gathered, then its result is
// held until its transfer; the next item is taken the cycle after. Bad index,
// full insert and empty delete leave the list untouched and are reported in
// status. No clearing pass is needed after reset.
module indexed_ordered_list_top
    import iol_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic        [MODE_W-1:0]   mode,
    input  logic        [POS_W-1:0]    position,
    input  logic signed [WORD_W-1:0]   value,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [WORD_W-1:0]   read_value,
    output logic        [COUNT_W-1:0]  entry_count,
    output logic        [STATUS_W-1:0] status
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    status_t            status_reg;
    status_t            status_next;
    logic [COUNT_W-1:0] entry_count_reg;
    logic [WORD_W-1:0]  read_value_reg;

    logic               accept;
    logic               capture;
    cell_ctrl_t         ctrl;
    cell_ctrl_t         ctrl_go;
    logic [MW-1:0]      pos_ext;
    logic [MW-1:0]      cnt_ext;
    logic [MW-1:0]      at_ext;
    logic [IW-1:0]      at;
    logic [WORD_W-1:0]  gather_word;
    logic [WORD_W-1:0]  cell_data [CAPACITY];
    logic [WORD_W-1:0]  hit_words [CAPACITY];

    assign accept  = item_valid && !item_stall;
    assign pos_ext = MW'(position);
    assign cnt_ext = MW'(count_reg);

    // operation decode and status
    always_comb
    begin
        ctrl        = '0;
        at_ext      = '0;
        status_next = STAT_OK;
        count_next  = count_reg;
        unique case (mode_t'(mode))
            MODE_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    ctrl.rd_en = 1'b1;
                    at_ext     = pos_ext;
                end
                else
                begin
                    status_next = STAT_RANGE;
                end
            end
            MODE_INS_FRONT, MODE_INS_BACK:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status_next = STAT_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_next = STAT_RANGE;
                end
                else
                begin
                    ctrl.ins_en = 1'b1;
                    at_ext      = (mode_t'(mode) == MODE_INS_FRONT) ? pos_ext
                                                                    : cnt_ext - pos_ext;
                    count_next  = count_reg + CW'(1);
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status_next = STAT_RANGE;
                end
                else
                begin
                    ctrl.del_en = 1'b1;
                    at_ext      = (mode_t'(mode) == MODE_DEL_FRONT)
                                  ? pos_ext : cnt_ext - MW'(1) - pos_ext;
                    count_next  = count_reg - CW'(1);
                end
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign at      = at_ext[IW-1:0];
    assign ctrl_go = accept ? ctrl : '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] prev_w;
        logic [WORD_W-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_mid_prev
            assign prev_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_mid_next
            assign next_w = cell_data[i+1];
        end

        iol_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl_go),
            .at        (at),
            .word      (value),
            .prev_word (prev_w),
            .next_word (next_w),
            .data      (cell_data[i]),
            .hit_word  (hit_words[i])
        );
    end

    iol_gather #(
        .CAPACITY (CAPACITY)
    ) u_gather (
        .clk       (clk),
        .load      (accept),
        .hit_words (hit_words),
        .word      (gather_word)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_GATHER;
                end
            end
            S_GATHER:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        item_stall   = 1'b1;
        result_valid = 1'b0;
        capture      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
            end
            S_GATHER:
            begin
                capture = 1'b1;
            end
            S_HOLD:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            entry_count_reg <= COUNT_W'(count_next);
        end
        if (capture)
        begin
            read_value_reg <= gather_word;
        end
    end

    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

    // occupancy never passes the cell count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("occupancy above capacity");

    // a rejected operation leaves the occupancy alone
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_next != STAT_OK)) |=> (count_reg == $past(count_reg)))
        else $error("occupancy changed on rejected operation");

    // every accepted item passes the gather state and then has its result offered
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 result_valid)
        else $error("result not offered after gather");

    // no new item while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item taken while result pending");

endmodule
